// ----- design/assert_macros.svh -----
// Assertion macros for the design modules.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Plain invariant: a condition that holds on every edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    `ASSERT_CLK(label, clk, rst_n, (cond))

`endif

// ----- design/bclt_pkg.sv -----
// Package for the button click LED timeout block: types, reset values, codes.
// No dependencies; used by all modules of the block.
package bclt_pkg;

    localparam int TIME_WIDTH_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int REMAIN_W       = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd100;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;
    localparam logic [CFG_W-1:0] TIMEOUT_RST    = 16'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_PRESS = 2'd1,
        EV_SHORT = 2'd2,
        EV_LONG  = 2'd3
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] long_press;
        logic [CFG_W-1:0] timeout;
    } t_cfg;

    // Item held in the input register.
    typedef struct packed {
        logic valid;
        logic level;
    } t_in_item;

endpackage

// ----- design/bclt_cfg.sv -----
// Configuration registers of the button click LED timeout block.
// Depends on bclt_pkg.
module bclt_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bclt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bclt_pkg::CFG_W-1:0]      i_cfg_data,
    output bclt_pkg::t_cfg                  o_cfg
);

    bclt_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce   <= bclt_pkg::DEBOUNCE_RST;
            r_cfg.long_press <= bclt_pkg::LONG_PRESS_RST;
            r_cfg.timeout    <= bclt_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bclt_pkg::CFG_DEBOUNCE:   r_cfg.debounce   <= i_cfg_data;
                bclt_pkg::CFG_LONG_PRESS: r_cfg.long_press <= i_cfg_data;
                bclt_pkg::CFG_TIMEOUT:    r_cfg.timeout    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/bclt_in_stage.sv -----
// Input register of the button click LED timeout block.
// Depends on bclt_pkg.
module bclt_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_button_level,
    input  logic               i_adv,
    output bclt_pkg::t_in_item o_item
);

    logic r_valid;
    logic r_level;

    // The register frees up in the same cycle that its item moves on.
    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_level <= i_button_level;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.level = r_level;

endmodule

// ----- design/bclt_core.sv -----
// Tick logic of the button click LED timeout block: debounce, press timing,
// LED off-timer state and the result register. Depends on bclt_pkg and
// assert_macros.svh.
`include "assert_macros.svh"

module bclt_core #(
    parameter int TIME_WIDTH = bclt_pkg::TIME_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bclt_pkg::t_cfg                 i_cfg,
    input  bclt_pkg::t_in_item             i_item,
    output logic                           o_adv,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_led_on,
    output logic [bclt_pkg::REMAIN_W-1:0]  o_remaining_ms,
    output bclt_pkg::t_event               o_event
);

    // Compare width covers both the counters and the 16-bit registers.
    localparam int CW = (TIME_WIDTH > bclt_pkg::CFG_W) ? TIME_WIDTH : bclt_pkg::CFG_W;
    localparam logic [TIME_WIDTH-1:0] CNT_MAX = {TIME_WIDTH{1'b1}};

    logic                  r_prev_level;
    logic [TIME_WIDTH-1:0] r_lockout;
    logic [TIME_WIDTH-1:0] r_press;
    logic                  r_led_lit;
    logic [TIME_WIDTH-1:0] r_countdown;

    logic                  r_out_valid;
    logic                  r_led_on;
    logic [bclt_pkg::REMAIN_W-1:0] r_remaining;
    bclt_pkg::t_event      r_event;

    logic                  n_prev_level;
    logic [TIME_WIDTH-1:0] n_lockout;
    logic [TIME_WIDTH-1:0] n_press;
    logic                  n_led_lit;
    logic [TIME_WIDTH-1:0] n_countdown;
    logic [bclt_pkg::REMAIN_W-1:0] n_remaining;
    bclt_pkg::t_event      n_event;

    logic                  step;
    logic [TIME_WIDTH-1:0] lock_inc;
    logic [TIME_WIDTH-1:0] press_inc;
    logic [TIME_WIDTH-1:0] timeout_load;
    logic [CW-1:0]         countdown_ext;
    logic                  edge_ok;

    assign o_adv = !r_out_valid || i_ready;
    assign step  = i_item.valid && o_adv;

    assign lock_inc  = (r_lockout == CNT_MAX) ? r_lockout : r_lockout + TIME_WIDTH'(1);
    assign press_inc = (r_press == CNT_MAX) ? r_press : r_press + TIME_WIDTH'(1);

    // A timeout beyond a narrow counter is loaded saturated.
    assign timeout_load = (CW'(i_cfg.timeout) > CW'(CNT_MAX)) ? CNT_MAX
                        : TIME_WIDTH'(CW'(i_cfg.timeout));

    assign edge_ok = (i_item.level != r_prev_level)
                  && (CW'(lock_inc) >= CW'(i_cfg.debounce));

    always_comb begin
        n_prev_level = i_item.level;
        n_lockout    = lock_inc;
        n_press      = press_inc;
        n_led_lit    = r_led_lit;
        n_countdown  = r_countdown;
        n_event      = bclt_pkg::EV_NONE;

        if (r_led_lit) begin
            if (r_countdown <= TIME_WIDTH'(1)) begin
                n_countdown = '0;
                n_led_lit   = 1'b0;
            end else begin
                n_countdown = r_countdown - TIME_WIDTH'(1);
            end
        end

        if (edge_ok) begin
            n_lockout = '0;
            if (!i_item.level) begin
                n_press = '0;
                n_event = bclt_pkg::EV_PRESS;
            end else if (CW'(press_inc) >= CW'(i_cfg.long_press)) begin
                n_led_lit   = 1'b0;
                n_countdown = '0;
                n_event     = bclt_pkg::EV_LONG;
            end else begin
                n_led_lit   = 1'b1;
                n_countdown = timeout_load;
                n_event     = bclt_pkg::EV_SHORT;
            end
        end
    end

    assign countdown_ext = CW'(n_countdown);
    assign n_remaining   = n_led_lit ? countdown_ext[bclt_pkg::REMAIN_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b1;
            r_lockout    <= CNT_MAX;
            r_press      <= '0;
            r_led_lit    <= 1'b0;
            r_countdown  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_adv) begin
                r_out_valid <= i_item.valid;
            end
            if (step) begin
                r_prev_level <= n_prev_level;
                r_lockout    <= n_lockout;
                r_press      <= n_press;
                r_led_lit    <= n_led_lit;
                r_countdown  <= n_countdown;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_led_on    <= n_led_lit;
            r_remaining <= n_remaining;
            r_event     <= n_event;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_led_on       = r_led_on;
    assign o_remaining_ms = r_remaining;
    assign o_event        = r_event;

    `ASSERT_ALWAYS(a_off_no_countdown, i_clk, i_rst_n, r_led_lit || (r_countdown == '0))
    `ASSERT_CLK(a_off_no_remaining, i_clk, i_rst_n, (r_out_valid && !r_led_on) |-> (r_remaining == '0))
    `ASSERT_CLK(a_long_turns_off, i_clk, i_rst_n, (r_out_valid && (r_event == bclt_pkg::EV_LONG)) |-> !r_led_on)
    `ASSERT_CLK(a_short_turns_on, i_clk, i_rst_n, (r_out_valid && (r_event == bclt_pkg::EV_SHORT)) |-> r_led_on)
    `ASSERT_CLK(a_edge_restarts_lockout, i_clk, i_rst_n, (step && edge_ok) |=> (r_lockout == '0))

endmodule

// ----- design/button_click_led_timeout.sv -----
// Button click LED timeout: each item is one millisecond tick with the raw active-low button
// level; the block debounces edges, times presses, and answers every tick with one result item
// (LED drive, ticks left on the off-timer, and the click event). One item is taken per clock
// cycle while o_ready is high. The input register takes the item at the accepting edge, and the
// result register then takes the tick logic's answer once the output is not stalled.
// Output stalls only hold up the input once both registers are full.
// Depends on bclt_pkg, bclt_cfg, bclt_in_stage and bclt_core.
module button_click_led_timeout #(
    parameter int TIME_WIDTH = bclt_pkg::TIME_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bclt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bclt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_button_level,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_led_on,
    output logic [bclt_pkg::REMAIN_W-1:0]  o_remaining_ms,
    output logic [1:0]                     o_event_code
);

    bclt_pkg::t_cfg     cfg;
    bclt_pkg::t_in_item item;
    bclt_pkg::t_event   event_code;
    logic               adv;

    bclt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bclt_in_stage u_in_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_button_level (i_button_level),
        .i_adv          (adv),
        .o_item         (item)
    );

    bclt_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_item         (item),
        .o_adv          (adv),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_led_on       (o_led_on),
        .o_remaining_ms (o_remaining_ms),
        .o_event        (event_code)
    );

    assign o_event_code = event_code;

endmodule

// ----- tb/sv/button_click_led_timeout_tb.sv -----
// Self-checking testbench for button_click_led_timeout: directed and random tick items.
// Each result item is checked against an in-bench model of the debounce and LED timer.
// Depends on bclt_pkg and the button_click_led_timeout RTL.
`timescale 1ns / 100ps

module button_click_led_timeout_tb;

    localparam int TW = bclt_pkg::TIME_WIDTH_DEF;
    localparam logic [TW-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic                          led_on;
        logic [bclt_pkg::REMAIN_W-1:0] remaining;
        bclt_pkg::t_event              ev;
    } t_tick_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [bclt_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bclt_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           i_valid;
    logic                           o_ready;
    logic                           i_button_level;
    logic                           o_valid;
    logic                           i_ready;
    logic                           o_led_on;
    logic [bclt_pkg::REMAIN_W-1:0]  o_remaining_ms;
    logic [1:0]                     o_event_code;

    // Model of the block: configuration and tick state.
    logic [bclt_pkg::CFG_W-1:0] cfg_debounce;
    logic [bclt_pkg::CFG_W-1:0] cfg_long_press;
    logic [bclt_pkg::CFG_W-1:0] cfg_timeout;
    logic                       prev_lvl;
    logic [TW-1:0]              lock_cnt;
    logic [TW-1:0]              press_cnt;
    logic                       led_lit;
    logic [TW-1:0]              off_cnt;

    t_tick_result expected_ticks[$];
    int           mismatch_cnt = 0;
    bit           tx_gaps_on   = 1'b0;
    bit           rx_stalls_on = 1'b0;
    int           hold_cycles  = 0;

    button_click_led_timeout u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_button_level (i_button_level),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_led_on       (o_led_on),
        .o_remaining_ms (o_remaining_ms),
        .o_event_code   (o_event_code)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_tick_result predict_tick(input logic lvl);
        t_tick_result r;
        r.ev = bclt_pkg::EV_NONE;
        if (lock_cnt != CNT_MAX) lock_cnt = lock_cnt + TW'(1);
        if (press_cnt != CNT_MAX) press_cnt = press_cnt + TW'(1);
        // The countdown runs before the edge so that a click this tick reloads it.
        if (led_lit) begin
            if (off_cnt <= TW'(1)) begin
                off_cnt = '0;
                led_lit = 1'b0;
            end else begin
                off_cnt = off_cnt - TW'(1);
            end
        end
        if (lvl != prev_lvl && lock_cnt >= cfg_debounce) begin
            lock_cnt = '0;
            if (lvl == 1'b0) begin
                press_cnt = '0;
                r.ev = bclt_pkg::EV_PRESS;
            end else if (press_cnt >= cfg_long_press) begin
                led_lit = 1'b0;
                off_cnt = '0;
                r.ev = bclt_pkg::EV_LONG;
            end else begin
                led_lit = 1'b1;
                off_cnt = cfg_timeout;
                r.ev = bclt_pkg::EV_SHORT;
            end
        end
        prev_lvl = lvl;
        r.led_on = led_lit;
        r.remaining = led_lit ? off_cnt[bclt_pkg::REMAIN_W-1:0] : '0;
        return r;
    endfunction

    function automatic logic [bclt_pkg::CFG_W-1:0] pick_cfg(input int lo, input int hi);
        if ($urandom_range(0, 5) == 0) return bclt_pkg::CFG_W'($urandom_range(lo, 65535));
        return bclt_pkg::CFG_W'($urandom_range(lo, hi));
    endfunction

    task automatic send_tick(input logic lvl);
        i_valid <= 1'b1;
        i_button_level <= lvl;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        expected_ticks.push_back(predict_tick(lvl));
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n) send_tick(lvl);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bclt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bclt_pkg::CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bclt_pkg::CFG_DEBOUNCE:   cfg_debounce = val;
            bclt_pkg::CFG_LONG_PRESS: cfg_long_press = val;
            bclt_pkg::CFG_TIMEOUT:    cfg_timeout = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [bclt_pkg::CFG_W-1:0] deb,
                              input logic [bclt_pkg::CFG_W-1:0] lp,
                              input logic [bclt_pkg::CFG_W-1:0] tmo);
        write_reg(bclt_pkg::CFG_DEBOUNCE, deb);
        write_reg(bclt_pkg::CFG_LONG_PRESS, lp);
        write_reg(bclt_pkg::CFG_TIMEOUT, tmo);
    endtask

    // The lockout counter sits saturated after reset, so the first press is accepted
    // even under the widest lockout; a quick bounce after it is not.
    task automatic test_reset_press();
        write_reg(bclt_pkg::CFG_DEBOUNCE, 16'hFFFF);
        send_run(1'b1, 2);
        send_tick(1'b0);
        send_tick(1'b1);
        send_run(1'b0, 3);
        drain_results();
        write_reg(bclt_pkg::CFG_DEBOUNCE, bclt_pkg::DEBOUNCE_RST);
    endtask

    task automatic test_click_and_long_press();
        set_config(16'd0, 16'd3, 16'd20);
        send_tick(1'b1);
        send_tick(1'b0);
        send_run(1'b1, 3);
        send_run(1'b0, 4);
        send_run(1'b1, 2);
        drain_results();
        // Short timeout: the LED must go dark on its own.
        write_reg(bclt_pkg::CFG_TIMEOUT, 16'd2);
        send_tick(1'b0);
        send_run(1'b1, 4);
        drain_results();
    endtask

    task automatic test_zero_timeout_and_long();
        set_config(16'd0, 16'd5, 16'd0);
        send_tick(1'b0);
        send_run(1'b1, 3);
        drain_results();
        write_reg(bclt_pkg::CFG_LONG_PRESS, 16'd0);
        send_tick(1'b0);
        send_run(1'b1, 2);
        drain_results();
    endtask

    task automatic test_debounce_lockout();
        set_config(16'd4, 16'd3, 16'd20);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_run(1'b0, 4);
        send_run(1'b1, 3);
        drain_results();
    endtask

    // With the widest lockout the press is ignored; the release then comes in alone.
    task automatic test_release_without_press();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_run(1'b0, 2);
        send_tick(1'b1);
        send_run(1'b0, 2);
        drain_results();
        write_reg(bclt_pkg::CFG_DEBOUNCE, 16'd0);
        send_run(1'b1, 3);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        set_config(16'd2, 16'd6, 16'd9);
        hold_cycles = 80;
        repeat (5) begin
            send_run(1'b0, $urandom_range(1, 10));
            send_run(1'b1, $urandom_range(1, 10));
        end
        drain_results();
    endtask

    task automatic test_random_gestures();
        logic lvl;
        int   len;
        int   span;
        int   sent;
        for (int p = 0; p < 5; p++) begin
            set_config(pick_cfg(0, 6), pick_cfg(1, 12), pick_cfg(1, 25));
            tx_gaps_on = (p < 4) && ($urandom_range(0, 3) != 0);
            rx_stalls_on = (p < 4) && ($urandom_range(0, 3) != 0);
            span = int'(cfg_long_press) + int'(cfg_debounce);
            span = (span > 30) ? 31 : span + 1;
            lvl = prev_lvl;
            sent = 0;
            while (sent < 100) begin
                lvl = ~lvl;
                // Mostly clean holds around the long-press limit, some contact bounce.
                if ($urandom_range(0, 9) < 3) len = $urandom_range(1, 2);
                else len = $urandom_range(1, 2 * span);
                send_run(lvl, len);
                sent += len;
            end
            drain_results();
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_tick_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (expected_ticks.size() == 0) begin
                $error("result item arrived with none expected");
                mismatch_cnt++;
            end else begin
                want = expected_ticks.pop_front();
                if (o_led_on !== want.led_on) begin
                    $error("led_on: expected %0d, got %0d", want.led_on, o_led_on);
                    mismatch_cnt++;
                end
                if (o_remaining_ms !== want.remaining) begin
                    $error("remaining_ms: expected %0d, got %0d", want.remaining,
                           o_remaining_ms);
                    mismatch_cnt++;
                end
                if (o_event_code !== want.ev) begin
                    $error("event_code: expected %0d, got %0d", want.ev, o_event_code);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Receiver side: random stall bursts, plus one long hold-off on request.
    initial begin : rx_stall
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_ready <= 1'b1;
            end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("** button_click_led_timeout: FAILED **");
        $finish;
    end

    initial begin : main
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= bclt_pkg::CFG_DEBOUNCE;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_button_level <= 1'b1;
        cfg_debounce = bclt_pkg::DEBOUNCE_RST;
        cfg_long_press = bclt_pkg::LONG_PRESS_RST;
        cfg_timeout = bclt_pkg::TIMEOUT_RST;
        prev_lvl = 1'b1;
        lock_cnt = CNT_MAX;
        press_cnt = '0;
        led_lit = 1'b0;
        off_cnt = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        test_reset_press();
        test_click_and_long_press();
        test_zero_timeout_and_long();
        test_debounce_lockout();
        test_release_without_press();
        test_output_backpressure();
        test_random_gestures();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("** button_click_led_timeout: PASSED **");
        end else begin
            $display("** button_click_led_timeout: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/bclt_pkg.sv
design/bclt_cfg.sv
design/bclt_in_stage.sv
design/bclt_core.sv
design/button_click_led_timeout.sv
tb/sv/button_click_led_timeout_tb.sv
